>>> hdl/itp_pkg.sv
// Shared types, constants and character helpers for the infix to prefix converter.
package itp_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic signed [3:0] PREC_OPEN  = -4'sd1;
    localparam logic signed [3:0] PREC_POW   = 4'sd6;
    localparam logic signed [3:0] PREC_MUL   = 4'sd5;
    localparam logic signed [3:0] PREC_ADD   = 4'sd4;
    localparam logic signed [3:0] PREC_OTHER = 4'sd0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_CHAR,
        S_POPR,
        S_POPR_W,
        S_POPP,
        S_POPP_W,
        S_FLUSH,
        S_FLUSH_W,
        S_EMIT_RD,
        S_EMIT_W,
        S_ERR
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] symbol;
        logic       last;
        t_status    status;
    } t_out_load;

    function automatic logic is_operand(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

    function automatic logic [7:0] swap_bracket(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_LPAREN) begin
            r = CH_RPAREN;
        end else if (c == CH_RPAREN) begin
            r = CH_LPAREN;
        end
        return r;
    endfunction

    function automatic logic signed [3:0] prec_of(input logic [7:0] c);
        logic signed [3:0] p;
        case (c)
            CH_LPAREN:          p = PREC_OPEN;
            CH_CARET:           p = PREC_POW;
            CH_STAR, CH_SLASH:  p = PREC_MUL;
            CH_PLUS, CH_MINUS:  p = PREC_ADD;
            default:            p = PREC_OTHER;
        endcase
        return p;
    endfunction

endpackage

>>> hdl/itp_out_stage.sv
// Output register stage that holds one result beat until the sink takes it.
module itp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itp_pkg::t_out_load i_load,
    output logic              o_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] out_symbol
    output logic              m_axis_tlast,   // out_last
    output logic [1:0]        m_axis_tuser    // [1:0] status
);

    logic             r_valid;
    logic [7:0]       r_symbol;
    logic             r_last;
    itp_pkg::t_status r_status;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load.valid) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_symbol <= i_load.symbol;
            r_last   <= i_load.last;
            r_status <= i_load.status;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_symbol;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_status;

endmodule

>>> hdl/infix_to_prefix_converter_core.sv
// Infix to prefix converter: character store, operator stack and output store sequencer.
// Load: one character beat per cycle in the load state; the scan starts after tlast.
// Scan: each character is read from the input store and then handled; a stack pop reads
// the stack, then moves the entry; then a flush. Stores and stack have registered reads.
// Emit: a read, then one beat per cycle while the slot is free; an error gives one beat.
// Reset (synchronous, active low) clears counts and control; the stores need no clearing.
module infix_to_prefix_converter_core #(
    parameter int MAX_LEN = itp_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // final_req
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic       m_axis_tlast,   // out_last
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN);

    itp_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_in_cnt, n_in_cnt;
    logic [CW-1:0]    r_sp, n_sp;
    logic [CW-1:0]    r_oc, n_oc;
    logic             r_ovf, n_ovf;
    itp_pkg::t_status r_status, n_status;
    logic [7:0]       r_cur, n_cur;

    logic [7:0] m_in [MAX_LEN];
    logic [7:0] m_st [MAX_LEN];
    logic [7:0] m_os [MAX_LEN];
    logic [7:0] r_in_rd, r_st_rd, r_os_rd;

    logic          in_we, in_re, st_we, st_re, os_we, os_re;
    logic [AW-1:0] in_ra, st_wa, st_ra, os_wa, os_ra;
    logic [7:0]    st_wd, os_wd;

    logic [CW-1:0] cnt_m1, sp_m1, oc_m1;
    logic          s_acc, room, ovf_end, slot_free;
    logic [7:0]    c_sw;
    itp_pkg::t_out_load out_load;

    assign cnt_m1 = r_in_cnt - 1'b1;
    assign sp_m1  = r_sp - 1'b1;
    assign oc_m1  = r_oc - 1'b1;

    assign s_axis_tready = (r_state == itp_pkg::S_LOAD);
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign room    = (r_in_cnt < LIMIT);
    assign ovf_end = r_ovf || !room;
    assign c_sw    = itp_pkg::swap_bracket(r_in_rd);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itp_pkg::S_LOAD: begin
                if (s_acc && s_axis_tlast) begin
                    n_state = ovf_end ? itp_pkg::S_ERR : itp_pkg::S_FETCH;
                end
            end
            itp_pkg::S_FETCH: begin
                n_state = (r_in_cnt == '0) ? itp_pkg::S_FLUSH : itp_pkg::S_CHAR;
            end
            itp_pkg::S_CHAR: begin
                if (itp_pkg::is_operand(c_sw) || c_sw == itp_pkg::CH_LPAREN) begin
                    n_state = itp_pkg::S_FETCH;
                end else if (c_sw == itp_pkg::CH_RPAREN) begin
                    n_state = itp_pkg::S_POPR;
                end else begin
                    n_state = itp_pkg::S_POPP;
                end
            end
            itp_pkg::S_POPR: begin
                n_state = (r_sp == '0) ? itp_pkg::S_ERR : itp_pkg::S_POPR_W;
            end
            itp_pkg::S_POPR_W: begin
                n_state = (r_st_rd == itp_pkg::CH_LPAREN) ? itp_pkg::S_FETCH : itp_pkg::S_POPR;
            end
            itp_pkg::S_POPP: begin
                n_state = (r_sp == '0) ? itp_pkg::S_FETCH : itp_pkg::S_POPP_W;
            end
            itp_pkg::S_POPP_W: begin
                n_state = (itp_pkg::prec_of(r_cur) < itp_pkg::prec_of(r_st_rd)) ?
                          itp_pkg::S_POPP : itp_pkg::S_FETCH;
            end
            itp_pkg::S_FLUSH: begin
                if (r_sp != '0) begin
                    n_state = itp_pkg::S_FLUSH_W;
                end else begin
                    n_state = (r_oc == '0) ? itp_pkg::S_ERR : itp_pkg::S_EMIT_RD;
                end
            end
            itp_pkg::S_FLUSH_W: begin
                n_state = (r_st_rd == itp_pkg::CH_LPAREN) ? itp_pkg::S_ERR : itp_pkg::S_FLUSH;
            end
            itp_pkg::S_EMIT_RD: begin
                n_state = itp_pkg::S_EMIT_W;
            end
            itp_pkg::S_EMIT_W: begin
                if (slot_free && r_oc == '0) begin
                    n_state = itp_pkg::S_LOAD;
                end
            end
            itp_pkg::S_ERR: begin
                if (slot_free) begin
                    n_state = itp_pkg::S_LOAD;
                end
            end
            default: n_state = itp_pkg::S_LOAD;
        endcase
    end

    // datapath control
    always_comb begin
        n_in_cnt = r_in_cnt;
        n_sp     = r_sp;
        n_oc     = r_oc;
        n_ovf    = r_ovf;
        n_status = r_status;
        n_cur    = r_cur;
        in_we    = 1'b0;
        in_re    = 1'b0;
        in_ra    = cnt_m1[AW-1:0];
        st_we    = 1'b0;
        st_wa    = r_sp[AW-1:0];
        st_wd    = r_cur;
        st_re    = 1'b0;
        st_ra    = sp_m1[AW-1:0];
        os_we    = 1'b0;
        os_wa    = r_oc[AW-1:0];
        os_wd    = r_st_rd;
        os_re    = 1'b0;
        os_ra    = oc_m1[AW-1:0];
        out_load = '{valid: 1'b0, symbol: 8'h00, last: 1'b1, status: itp_pkg::ST_OK};
        case (r_state)
            itp_pkg::S_LOAD: begin
                if (s_acc) begin
                    if (room) begin
                        in_we    = 1'b1;
                        n_in_cnt = r_in_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_sp     = '0;
                        n_oc     = '0;
                        n_status = itp_pkg::ST_TOO_LONG;
                    end
                end
            end
            itp_pkg::S_FETCH: begin
                if (r_in_cnt != '0) begin
                    in_re    = 1'b1;
                    n_in_cnt = cnt_m1;
                end
            end
            itp_pkg::S_CHAR: begin
                n_cur = c_sw;
                if (itp_pkg::is_operand(c_sw)) begin
                    os_we = 1'b1;
                    os_wd = c_sw;
                    n_oc  = r_oc + 1'b1;
                end else if (c_sw == itp_pkg::CH_LPAREN) begin
                    st_we = 1'b1;
                    st_wd = c_sw;
                    n_sp  = r_sp + 1'b1;
                end
            end
            itp_pkg::S_POPR, itp_pkg::S_FLUSH: begin
                if (r_sp == '0) begin
                    n_status = (r_state == itp_pkg::S_POPR) ? itp_pkg::ST_UNMATCHED :
                                                               itp_pkg::ST_EMPTY;
                end else begin
                    st_re = 1'b1;
                    n_sp  = sp_m1;
                end
            end
            itp_pkg::S_POPR_W, itp_pkg::S_FLUSH_W: begin
                if (r_st_rd == itp_pkg::CH_LPAREN) begin
                    n_status = itp_pkg::ST_UNMATCHED;
                end else begin
                    os_we = 1'b1;
                    n_oc  = r_oc + 1'b1;
                end
            end
            itp_pkg::S_POPP: begin
                if (r_sp == '0) begin
                    st_we = 1'b1;
                    n_sp  = r_sp + 1'b1;
                end else begin
                    st_re = 1'b1;
                end
            end
            itp_pkg::S_POPP_W: begin
                if (itp_pkg::prec_of(r_cur) < itp_pkg::prec_of(r_st_rd)) begin
                    os_we = 1'b1;
                    n_oc  = r_oc + 1'b1;
                    n_sp  = sp_m1;
                end else begin
                    st_we = 1'b1;
                    n_sp  = r_sp + 1'b1;
                end
            end
            itp_pkg::S_EMIT_RD: begin
                os_re = 1'b1;
                n_oc  = oc_m1;
            end
            itp_pkg::S_EMIT_W: begin
                if (slot_free) begin
                    out_load = '{valid: 1'b1, symbol: r_os_rd, last: (r_oc == '0),
                                 status: itp_pkg::ST_OK};
                    // prefetch the next character while this beat goes out
                    if (r_oc != '0) begin
                        os_re = 1'b1;
                        n_oc  = oc_m1;
                    end
                end
            end
            itp_pkg::S_ERR: begin
                if (slot_free) begin
                    out_load = '{valid: 1'b1, symbol: 8'h00, last: 1'b1, status: r_status};
                    n_in_cnt = '0;
                    n_ovf    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itp_pkg::S_LOAD;
            r_in_cnt <= '0;
            r_sp     <= '0;
            r_oc     <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_cnt <= n_in_cnt;
            r_sp     <= n_sp;
            r_oc     <= n_oc;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_cur    <= n_cur;
    end

    // input store
    always_ff @(posedge i_clk) begin
        if (in_we) begin
            m_in[r_in_cnt[AW-1:0]] <= s_axis_tdata;
        end
        if (in_re) begin
            r_in_rd <= m_in[in_ra];
        end
    end

    // operator stack: reads and writes fall in different states, so never collide
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_st[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_st_rd <= m_st[st_ra];
        end
    end

    // output store, read back from the top to give prefix order
    always_ff @(posedge i_clk) begin
        if (os_we) begin
            m_os[os_wa] <= os_wd;
        end
        if (os_re) begin
            r_os_rd <= m_os[os_ra];
        end
    end

    itp_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .o_free        (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> hdl/itp_checker.sv
// Port-level checks for the infix to prefix converter, bound to the top level.
module itp_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // an error is a single zero beat that closes the expression
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != itp_pkg::ST_OK |->
            m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("error beat without tlast or with data");

    // no new characters are taken while an expression is still being emitted
    a_no_load_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of an emission");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind infix_to_prefix_converter_core itp_props u_itp_props (.*);

>>> tb/itp_checker.sv
// Result checker for the infix to prefix converter: watches both streams and predicts the output.
module itp_checker #(
    parameter int MAX_LEN = itp_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] symbol
    input  logic       i_s_tlast,    // final_req
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] out_symbol
    input  logic       i_m_tlast,    // out_last
    input  logic [1:0] i_m_tuser,    // [1:0] status
    output int         o_fails,
    output int         o_pending,
    output int         o_checked,
    output int         o_error_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       ch;
        logic             fin;
        itp_pkg::t_status status;
    } t_result;

    t_result    prefix_q[$];
    logic [7:0] char_store [MAX_LEN];
    logic [7:0] op_stack [MAX_LEN];
    logic [7:0] out_store [MAX_LEN];
    int         char_count = 0;
    int         op_depth = 0;
    int         out_count = 0;
    bit         too_long = 1'b0;
    int         fails = 0;
    int         checked = 0;
    int         error_beats = 0;

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic int rank_of(input logic [7:0] c);
        int r;
        case (c)
            itp_pkg::CH_LPAREN:                  r = -1;
            itp_pkg::CH_CARET:                   r = 6;
            itp_pkg::CH_STAR, itp_pkg::CH_SLASH: r = 5;
            itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: r = 4;
            default:                             r = 0;
        endcase
        return r;
    endfunction

    function automatic void put_out(input logic [7:0] c);
        if (out_count < MAX_LEN) begin
            out_store[out_count] = c;
            out_count++;
        end
    endfunction

    function automatic void push_op(input logic [7:0] c);
        if (op_depth < MAX_LEN) begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    // Scan the stored characters backwards with brackets swapped; out_store ends up reversed.
    function automatic itp_pkg::t_status scan_chars();
        int         i;
        logic [7:0] c;
        bit         found;
        for (i = char_count - 1; i >= 0; i--) begin
            c = char_store[i];
            if (c == itp_pkg::CH_LPAREN) begin
                c = itp_pkg::CH_RPAREN;
            end else if (c == itp_pkg::CH_RPAREN) begin
                c = itp_pkg::CH_LPAREN;
            end
            if (is_alnum(c)) begin
                put_out(c);
            end else if (c == itp_pkg::CH_LPAREN) begin
                push_op(c);
            end else if (c == itp_pkg::CH_RPAREN) begin
                found = 1'b0;
                while (op_depth > 0 && !found) begin
                    op_depth--;
                    if (op_stack[op_depth] == itp_pkg::CH_LPAREN) begin
                        found = 1'b1;
                    end else begin
                        put_out(op_stack[op_depth]);
                    end
                end
                if (!found) begin
                    return itp_pkg::ST_UNMATCHED;
                end
            end else begin
                while (op_depth > 0 && rank_of(c) < rank_of(op_stack[op_depth - 1])) begin
                    op_depth--;
                    put_out(op_stack[op_depth]);
                end
                push_op(c);
            end
        end
        while (op_depth > 0) begin
            op_depth--;
            if (op_stack[op_depth] == itp_pkg::CH_LPAREN) begin
                return itp_pkg::ST_UNMATCHED;
            end
            put_out(op_stack[op_depth]);
        end
        if (out_count == 0) begin
            return itp_pkg::ST_EMPTY;
        end
        return itp_pkg::ST_OK;
    endfunction

    function automatic void take_char(input logic [7:0] sym, input logic fin);
        itp_pkg::t_status st;
        t_result          r;
        int               k;
        if (char_count < MAX_LEN) begin
            char_store[char_count] = sym;
            char_count++;
        end else begin
            too_long = 1'b1;
        end
        if (fin) begin
            op_depth = 0;
            out_count = 0;
            st = too_long ? itp_pkg::ST_TOO_LONG : scan_chars();
            if (st != itp_pkg::ST_OK) begin
                r.ch = 8'h00;
                r.fin = 1'b1;
                r.status = st;
                prefix_q = {prefix_q, r};
            end else begin
                for (k = 0; k < out_count; k++) begin
                    r.ch = out_store[out_count - 1 - k];
                    r.fin = (k == out_count - 1);
                    r.status = itp_pkg::ST_OK;
                    prefix_q = {prefix_q, r};
                end
            end
            char_count = 0;
            op_depth = 0;
            out_count = 0;
            too_long = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            prefix_q.delete();
            char_count = 0;
            op_depth = 0;
            out_count = 0;
            too_long = 1'b0;
        end else begin
            // check the output beat first: it always belongs to an earlier expression
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                if (i_m_tuser != itp_pkg::ST_OK) begin
                    error_beats++;
                end
                if (prefix_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected beat sym %02h last %0d status %0d", $realtime,
                                 i_m_tdata, i_m_tlast, i_m_tuser);
                    end
                end else begin
                    want = prefix_q.pop_front();
                    if (want.ch !== i_m_tdata || want.fin !== i_m_tlast ||
                        want.status !== i_m_tuser) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch, expected sym %02h last %0d status %0d",
                                     $realtime, want.ch, want.fin, want.status);
                            $display("    got sym %02h last %0d status %0d",
                                     i_m_tdata, i_m_tlast, i_m_tuser);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_char(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= prefix_q.size();
        o_fails <= fails;
        o_checked <= checked;
        o_error_beats <= error_beats;
    end

endmodule

>>> tb/infix_to_prefix_converter_core_tb.sv
// Top of the infix to prefix converter testbench: clock, reset, stimulus and verdict.
module infix_to_prefix_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN       = itp_pkg::MAX_LEN_DEF;
    localparam int RX_HOLD       = 400;
    localparam int STALL_LIMIT   = 6000;
    localparam int RANDOM_BEATS  = 300;
    localparam int TOTAL_BEATS   = 330;
    localparam int SETTLE_CYCLES = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] symbol
    logic       s_axis_tlast = 1'b0;   // final_req
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_symbol
    logic       m_axis_tlast;          // out_last
    logic [1:0] m_axis_tuser;          // [1:0] status

    int         fails;
    int         pending;
    int         checked;
    int         error_beats;

    bit         quiet = 1'b0;
    bit         burst_free = 1'b0;
    int         hold_requests = 0;
    int         holds_done = 0;
    int         beats_sent = 0;
    int         exprs_sent = 0;
    int         idle_cycles = 0;
    logic [7:0] expr_buf[$];
    string      filler = " %!=&<>~,;";

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    infix_to_prefix_converter_core #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    itp_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .i_m_tuser     (m_axis_tuser),
        .o_fails       (fails),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_error_beats (error_beats)
    );

    // Result side: random back-pressure bursts, plus a long hold-off on request.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
                holds_done++;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stop the run when nothing moves on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles with %0d results outstanding", idle_cycles, pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Append one character to the expression being built.
    function automatic void add_char(input logic [7:0] c);
        expr_buf = {expr_buf, c};
    endfunction

    task automatic send_beat(input logic [7:0] sym, input logic fin);
        int gap;
        gap = 0;
        if (!quiet && !burst_free && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sym;
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic send_buf();
        int i;
        for (i = 0; i < expr_buf.size(); i++) begin
            send_beat(expr_buf[i], i == expr_buf.size() - 1);
        end
        exprs_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        expr_buf.delete();
        for (i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
        send_buf();
    endtask

    // Pause the sender until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_operand();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 61);
        if (r < 26) begin
            c = 8'h61 + r[7:0];
        end else if (r < 52) begin
            c = 8'h41 + r[7:0] - 8'd26;
        end else begin
            c = 8'h30 + r[7:0] - 8'd52;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_op(input bit plain);
        logic [7:0] c;
        case ($urandom_range(0, plain ? 4 : 6))
            0: c = itp_pkg::CH_CARET;
            1: c = itp_pkg::CH_STAR;
            2: c = itp_pkg::CH_SLASH;
            3: c = itp_pkg::CH_PLUS;
            4: c = itp_pkg::CH_MINUS;
            default: c = filler[$urandom_range(0, filler.len() - 1)];
        endcase
        return c;
    endfunction

    task automatic build_wellformed(input int n_operands);
        int i;
        int open;
        expr_buf.delete();
        open = 0;
        for (i = 0; i < n_operands; i++) begin
            if (i > 0) begin
                add_char(pick_op(1'b0));
            end
            while (open < 6 && $urandom_range(0, 3) == 0) begin
                add_char(itp_pkg::CH_LPAREN);
                open++;
            end
            add_char(pick_operand());
            while (open > 0 && $urandom_range(0, 2) == 0) begin
                add_char(itp_pkg::CH_RPAREN);
                open--;
            end
        end
        while (open > 0) begin
            add_char(itp_pkg::CH_RPAREN);
            open--;
        end
    endtask

    // Alternate operands and plain operators to an exact length, no brackets.
    task automatic build_chain(input int n_chars);
        int i;
        expr_buf.delete();
        for (i = 0; i < n_chars; i++) begin
            add_char((i % 2 == 0) ? pick_operand() : pick_op(1'b1));
        end
    endtask

    task automatic build_broken();
        int idx;
        int i;
        build_wellformed($urandom_range(1, 6));
        idx = $urandom_range(0, expr_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: begin
                if (expr_buf.size() > 1) begin
                    expr_buf.delete(idx);
                end
            end
            1: expr_buf.insert(idx, $urandom_range(0, 1) ? itp_pkg::CH_LPAREN :
                                                            itp_pkg::CH_RPAREN);
            2: expr_buf[idx] = 8'($urandom_range(0, 255));
            default: begin
                // brackets and nothing else
                expr_buf.delete();
                for (i = 0; i < $urandom_range(1, 6); i++) begin
                    add_char($urandom_range(0, 1) ? itp_pkg::CH_LPAREN : itp_pkg::CH_RPAREN);
                end
            end
        endcase
    endtask

    task automatic build_noise();
        int i;
        int n;
        expr_buf.delete();
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
            add_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random();
        int pick;
        burst_free <= ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            build_wellformed($urandom_range(1, 8));
        end else if (pick < 9) begin
            build_broken();
        end else begin
            build_noise();
        end
        send_buf();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single operand, all operators, both unmatched kinds, empty, filler chars
        send_text("a");
        send_text("(a+b)*c");
        send_text("a^b/c-d");
        send_text("(");
        send_text(")");
        send_text("()");
        send_text("a b");
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        exprs_sent += 2;
        drain();

        // longest accepted expression, then two past the store size
        build_chain(MAX_LEN);
        send_buf();
        build_chain(MAX_LEN + 2);
        send_buf();

        // hold the result side off while expressions keep coming
        hold_requests <= hold_requests + 1;
        repeat (8) send_random();

        while (beats_sent < RANDOM_BEATS) begin
            send_random();
            if (beats_sent > 200 && beats_sent < 215) begin
                drain();
            end
        end

        quiet <= 1'b1;
        burst_free <= 1'b1;
        while (beats_sent < TOTAL_BEATS) begin
            build_wellformed($urandom_range(1, 6));
            send_buf();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters in %0d expressions: well-formed, broken, noise and overlong.",
                 beats_sent, exprs_sent);
        $display("Checked %0d result beats, %0d of them error reports; %0d mismatches.",
                 checked, error_beats, fails);
        if (fails == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/itp_pkg.sv
hdl/itp_out_stage.sv
hdl/infix_to_prefix_converter_core.sv
hdl/itp_checker.sv
tb/itp_checker.sv
tb/infix_to_prefix_converter_core_tb.sv
